// File: design/g2enu_pkg.sv
// Shared constants, types and helper functions for the geographic to ENU core.
// No dependencies; imported by g2enu_cordic, g2enu_mulq and the top level.
`default_nettype none

package g2enu_pkg;

    localparam int ANGLE_W  = 31;   // angle port width (longitude format)
    localparam int TRIG_W   = 32;   // Q1.30 sine/cosine
    localparam int Z_W      = 33;   // CORDIC residual angle, Q2.30
    localparam int OUT_W    = 36;   // east/north/up width
    localparam int CORDIC_STEPS = 30;

    localparam longint PI_Q30          = 64'sd3373259426;
    localparam longint HALF_PI_Q30     = 64'sd1686629713;
    localparam longint TWO_PI_Q30      = 64'sd6746518852;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint RADIUS_METRES   = 64'sd6371229;

    typedef enum logic [1:0] {
        CFG_RADIUS     = 2'd0,
        CFG_ORIGIN_LON = 2'd1,
        CFG_ORIGIN_LAT = 2'd2
    } cfg_addr_t;

    // Rotation angle of CORDIC step i, Q2.30.
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0: a = 33'sd843314856;
            1: a = 33'sd497837829;
            2: a = 33'sd263043836;
            3: a = 33'sd133525158;
            4: a = 33'sd67021686;
            5: a = 33'sd33543515;
            6: a = 33'sd16775850;
            7: a = 33'sd8388437;
            8: a = 33'sd4194282;
            9: a = 33'sd2097149;
            default: a = Z_W'(longint'(1) <<< (30 - i));
        endcase
        return a;
    endfunction

    // Register stages through g2enu_cordic for a given angle format.
    function automatic int trig_latency(input int afb);
        return 65 - afb;
    endfunction

endpackage

`default_nettype wire

// File: design/geographic_to_enu_transform_core.sv
// Geographic point to local east-north-up converter on a spherical Earth.
// Uses g2enu_pkg, g2enu_cordic and g2enu_mulq.
//
// One point enters per clock and one east/north/up item leaves per point, in
// order. The pipeline is 76 - ANGLE_FRAC_BITS stages deep (48 at the default
// angle format): the 30-step CORDIC (one step per stage, plus 2*pi reduction
// stages that grow as ANGLE_FRAC_BITS shrinks), three chained 3-stage
// multipliers, a difference and a sum register. Output and skid registers
// follow; the first result is visible in the cycle after the last stage. The
// whole pipeline stalls only when the skid register is full. Write
// configuration (radius, origin longitude and latitude over APB) only while
// the core is idle; the core does not enforce this. The origin's trigonometry is
// recomputed in its own CORDIC lanes per item, so new origin values apply to
// the next item with no warm-up. Results outside the 36-bit range saturate.
`default_nettype none

module geographic_to_enu_transform_core
    import g2enu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int DIST_FRAC_BITS  = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // point input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [30:0] s_longitude,
    input  wire logic signed [29:0] s_latitude,
    input  wire logic signed [31:0] s_elevation,
    // ENU output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [OUT_W-1:0] m_east,
    output logic signed [OUT_W-1:0] m_north,
    output logic signed [OUT_W-1:0] m_up
);

    localparam int T   = trig_latency(ANGLE_FRAC_BITS);
    localparam int LAT = T + 11;
    localparam longint RAD_FULL = RADIUS_METRES <<< DIST_FRAC_BITS;
    localparam logic [31:0] RADIUS_RESET =
        (RAD_FULL > 64'sd4294967295) ? 32'hFFFF_FFFF : RAD_FULL[31:0];
    localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));

    typedef struct packed {
        logic signed [TRIG_W-1:0] sn, cn, osn, ocn, osa, oca;
    } carry1_t;

    typedef struct packed {
        logic signed [33:0]       pz;
        logic signed [33:0]       oz;
        logic signed [TRIG_W-1:0] ksc, kss, kcc, kcs, osn, ocn, osa, oca;
    } carry2_t;

    typedef struct packed {
        logic signed [34:0]       dx, dy, dz;
        logic signed [TRIG_W-1:0] ksc, kss, kcc, kcs, osn, ocn, osa, oca;
    } diff_t;

    // ---------------- configuration ----------------
    logic [31:0]        radius_reg;
    logic signed [30:0] olon_reg;
    logic signed [29:0] olat_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            olon_reg   <= '0;
            olat_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_addr_t'(paddr[3:2]))
                CFG_RADIUS:     radius_reg <= pwdata;
                CFG_ORIGIN_LON: olon_reg   <= pwdata[30:0];
                CFG_ORIGIN_LAT: olat_reg   <= pwdata[29:0];
                default: ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_addr_t'(paddr[3:2]))
            CFG_RADIUS:     prdata = radius_reg;
            CFG_ORIGIN_LON: prdata = 32'(olon_reg);
            CFG_ORIGIN_LAT: prdata = 32'(olat_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // The whole pipeline advances together unless the skid register holds an item.
    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic             out_v_reg, skid_v_reg;
    logic             last_v;

    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign last_v  = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // ---------------- trigonometry ----------------
    logic signed [TRIG_W-1:0] sn, cn, sa, ca, osn, ocn, osa, oca;

    g2enu_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lon (
        .aclk(aclk), .en(en), .angle(s_longitude), .sin_q(sn), .cos_q(cn));
    g2enu_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lat (
        .aclk(aclk), .en(en), .angle(ANGLE_W'(s_latitude)), .sin_q(sa), .cos_q(ca));
    g2enu_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_olon (
        .aclk(aclk), .en(en), .angle(olon_reg), .sin_q(osn), .cos_q(ocn));
    g2enu_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_olat (
        .aclk(aclk), .en(en), .angle(ANGLE_W'(olat_reg)), .sin_q(osa), .cos_q(oca));

    // Hold elevation alongside the CORDIC lanes.
    logic signed [31:0] elev_reg [0:T-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            elev_reg[0] <= s_elevation;
            for (int i = 1; i < T; i++) begin
                elev_reg[i] <= elev_reg[i-1];
            end
        end
    end

    // ---------------- first products ----------------
    // A sine or cosine can land a few units above 1.0, so the origin terms
    // keep one bit of headroom over the radius.
    logic signed [33:0]       w;
    logic signed [32:0]       r0;
    logic signed [33:0]       t, pz, t0, oz;
    logic signed [TRIG_W-1:0] ksc, kss, kcc, kcs;
    carry1_t                  c1_reg [0:2];

    assign r0 = $signed({1'b0, radius_reg});
    assign w  = $signed({2'b00, radius_reg}) + 34'(elev_reg[T-1]);

    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_t   (.aclk, .en, .a(w),   .b(ca),  .p(t));
    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_pz  (.aclk, .en, .a(w),   .b(sa),  .p(pz));
    g2enu_mulq #(.A_W(33), .B_W(32), .P_W(34)) u_t0  (.aclk, .en, .a(r0),  .b(oca), .p(t0));
    g2enu_mulq #(.A_W(33), .B_W(32), .P_W(34)) u_oz  (.aclk, .en, .a(r0),  .b(osa), .p(oz));
    g2enu_mulq #(.A_W(32), .B_W(32), .P_W(32)) u_ksc (.aclk, .en, .a(osa), .b(ocn), .p(ksc));
    g2enu_mulq #(.A_W(32), .B_W(32), .P_W(32)) u_kss (.aclk, .en, .a(osa), .b(osn), .p(kss));
    g2enu_mulq #(.A_W(32), .B_W(32), .P_W(32)) u_kcc (.aclk, .en, .a(oca), .b(ocn), .p(kcc));
    g2enu_mulq #(.A_W(32), .B_W(32), .P_W(32)) u_kcs (.aclk, .en, .a(oca), .b(osn), .p(kcs));

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg[0] <= '{sn: sn, cn: cn, osn: osn, ocn: ocn, osa: osa, oca: oca};
            c1_reg[1] <= c1_reg[0];
            c1_reg[2] <= c1_reg[1];
        end
    end

    // ---------------- second products ----------------
    logic signed [33:0] px, py, ox, oy;
    carry2_t            c2_reg [0:2];

    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_px (
        .aclk, .en, .a(t),  .b(c1_reg[2].cn),  .p(px));
    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_py (
        .aclk, .en, .a(t),  .b(c1_reg[2].sn),  .p(py));
    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_ox (
        .aclk, .en, .a(t0), .b(c1_reg[2].ocn), .p(ox));
    g2enu_mulq #(.A_W(34), .B_W(32), .P_W(34)) u_oy (
        .aclk, .en, .a(t0), .b(c1_reg[2].osn), .p(oy));

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg[0] <= '{pz: pz, oz: oz, ksc: ksc, kss: kss, kcc: kcc, kcs: kcs,
                           osn: c1_reg[2].osn, ocn: c1_reg[2].ocn,
                           osa: c1_reg[2].osa, oca: c1_reg[2].oca};
            c2_reg[1] <= c2_reg[0];
            c2_reg[2] <= c2_reg[1];
        end
    end

    // ---------------- offset from origin ----------------
    diff_t d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.dx  <= 35'(px) - 35'(ox);
            d_reg.dy  <= 35'(py) - 35'(oy);
            d_reg.dz  <= 35'(c2_reg[2].pz) - 35'(c2_reg[2].oz);
            d_reg.ksc <= c2_reg[2].ksc;
            d_reg.kss <= c2_reg[2].kss;
            d_reg.kcc <= c2_reg[2].kcc;
            d_reg.kcs <= c2_reg[2].kcs;
            d_reg.osn <= c2_reg[2].osn;
            d_reg.ocn <= c2_reg[2].ocn;
            d_reg.osa <= c2_reg[2].osa;
            d_reg.oca <= c2_reg[2].oca;
        end
    end

    // ---------------- rotation ----------------
    logic signed [34:0] e1, e2, n1, n2, n3, u1, u2, u3;

    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_e1 (
        .aclk, .en, .a(d_reg.dx), .b(d_reg.osn), .p(e1));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_e2 (
        .aclk, .en, .a(d_reg.dy), .b(d_reg.ocn), .p(e2));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_n1 (
        .aclk, .en, .a(d_reg.dx), .b(d_reg.ksc), .p(n1));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_n2 (
        .aclk, .en, .a(d_reg.dy), .b(d_reg.kss), .p(n2));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_n3 (
        .aclk, .en, .a(d_reg.dz), .b(d_reg.oca), .p(n3));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_u1 (
        .aclk, .en, .a(d_reg.dx), .b(d_reg.kcc), .p(u1));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_u2 (
        .aclk, .en, .a(d_reg.dy), .b(d_reg.kcs), .p(u2));
    g2enu_mulq #(.A_W(35), .B_W(32), .P_W(35)) u_u3 (
        .aclk, .en, .a(d_reg.dz), .b(d_reg.osa), .p(u3));

    // ---------------- sum and saturate ----------------
    logic signed [36:0]      e_sum, n_sum, u_sum;
    logic signed [OUT_W-1:0] e_reg, n_reg, u_reg;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [36:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > $signed(37'(OUT_MAX))) begin
            r = OUT_W'(OUT_MAX);
        end else if (v < $signed(37'(OUT_MIN))) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    assign e_sum = 37'(e2) - 37'(e1);
    assign n_sum = 37'(n3) - 37'(n1) - 37'(n2);
    assign u_sum = 37'(u1) + 37'(u2) + 37'(u3);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= sat(e_sum);
            n_reg <= sat(n_sum);
            u_reg <= sat(u_sum);
        end
    end

    // ---------------- output register and skid ----------------
    logic signed [OUT_W-1:0] oe_reg, on_reg, ou_reg, se_reg, sn_reg, su_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= last_v;
            end
        end else if (last_v && en) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                oe_reg <= se_reg;
                on_reg <= sn_reg;
                ou_reg <= su_reg;
            end else begin
                oe_reg <= e_reg;
                on_reg <= n_reg;
                ou_reg <= u_reg;
            end
        end else if (last_v && en) begin
            se_reg <= e_reg;
            sn_reg <= n_reg;
            su_reg <= u_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_east  = oe_reg;
    assign m_north = on_reg;
    assign m_up    = ou_reg;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds an item while output register is empty");

    a_freeze_on_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |=> $stable(vld_reg))
        else $error("pipeline advanced while skid register was full");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_ready))
        else $error("skid filled without a stalled output");

endmodule

`default_nettype wire

// File: design/g2enu_mulq.sv
// Pipelined signed product scaled by 2^-30, rounded half away from zero.
// Three register stages; uses g2enu_pkg.
`default_nettype none

module g2enu_mulq
    import g2enu_pkg::*;
#(
    parameter int A_W = 34,
    parameter int B_W = 32,
    parameter int P_W = 34
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0]      p
);

    localparam int LO_W = (A_W + 1) / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int S_W  = A_W + B_W + 1;
    localparam int M_W  = S_W - 30;

    logic [A_W-1:0]         ua_reg;
    logic [B_W-1:0]         ub_reg;
    logic                   neg1_reg, neg2_reg;
    logic [HI_W+B_W-1:0]    ph_reg;
    logic [LO_W+B_W-1:0]    pl_reg;
    logic signed [P_W-1:0]  p_reg;
    logic [S_W-1:0]         sum;
    logic [M_W-1:0]         mag;

    // Split the wide operand so each partial product stays narrow.
    always_comb begin
        sum = (S_W'(ph_reg) << LO_W) + S_W'(pl_reg) + (S_W'(1) << 29);
        mag = sum[S_W-1:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg   <= a[A_W-1] ? A_W'(-a) : A_W'(a);
            ub_reg   <= b[B_W-1] ? B_W'(-b) : B_W'(b);
            neg1_reg <= a[A_W-1] ^ b[B_W-1];
            ph_reg   <= (HI_W+B_W)'(ua_reg[A_W-1:LO_W]) * (HI_W+B_W)'(ub_reg);
            pl_reg   <= (LO_W+B_W)'(ua_reg[LO_W-1:0]) * (LO_W+B_W)'(ub_reg);
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? -$signed(P_W'(mag)) : $signed(P_W'(mag));
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: design/g2enu_cordic.sv
// Pipelined sine/cosine: modulo 2*pi reduction, quadrant fold, 30 CORDIC steps.
// One register per step; uses g2enu_pkg.
`default_nettype none

module g2enu_cordic
    import g2enu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]       sin_q,
    output logic signed [TRIG_W-1:0]       cos_q
);

    localparam int K  = 30 - ANGLE_FRAC_BITS;
    localparam int VW = 35 + K;
    localparam int RW = 35;
    localparam longint OFFSET = TWO_PI_Q30 <<< K;

    logic signed [VW-1:0]     v_reg [0:K+1];
    logic signed [RW-1:0]     r_reg;
    logic signed [RW-1:0]     fold;
    logic                     flip_fold;
    logic signed [TRIG_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]    z_reg [0:CORDIC_STEPS];
    logic                     flip_reg [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    // Offset by a multiple of 2*pi so the value is never negative.
    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= (VW'(angle) <<< K) + $signed(OFFSET[VW-1:0]);
        end
    end

    // Strip one power-of-two multiple of 2*pi per stage.
    for (genvar g = 0; g <= K; g++) begin : g_reduce
        localparam longint STEP = TWO_PI_Q30 <<< (K - g);
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[g+1] <= (v_reg[g] >= $signed(STEP[VW-1:0]))
                    ? v_reg[g] - $signed(STEP[VW-1:0]) : v_reg[g];
            end
        end
    end

    always_comb begin
        flip_fold = 1'b0;
        fold      = r_reg;
        if (r_reg > $signed(HALF_PI_Q30[RW-1:0])) begin
            fold      = $signed(PI_Q30[RW-1:0]) - r_reg;
            flip_fold = 1'b1;
        end else if (r_reg < -$signed(HALF_PI_Q30[RW-1:0])) begin
            fold      = -$signed(PI_Q30[RW-1:0]) - r_reg;
            flip_fold = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= (v_reg[K+1][RW-1:0] >= $signed(PI_Q30[RW-1:0]))
                ? v_reg[K+1][RW-1:0] - $signed(TWO_PI_Q30[RW-1:0])
                : v_reg[K+1][RW-1:0];
            x_reg[0]    <= $signed(CORDIC_GAIN_Q30[TRIG_W-1:0]);
            y_reg[0]    <= '0;
            z_reg[0]    <= fold[Z_W-1:0];
            flip_reg[0] <= flip_fold;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN = atan_q30(i);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][Z_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= y_reg[CORDIC_STEPS];
            cos_reg <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire
